FILE: rtl/core/idiv_pkg.sv
// Shared constants and control types for the signed/unsigned integer divider.
package idiv_pkg;

    // Port widths of the item fields
    localparam int FIELD_WIDTH = 32;
    localparam int MODE_WIDTH  = 2;
    // Widest supported datapath and its default
    localparam int MAX_WIDTH   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Mode bit positions
    localparam int MODE_REM_BIT    = 0;
    localparam int MODE_SIGNED_BIT = 1;

    // Control from the sequencer to the shift-subtract unit
    typedef struct packed {
        logic start;
    } core_ctrl_t;

    // Status from the shift-subtract unit
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

FILE: rtl/core/idiv_core.sv
// Radix-2 restoring shift-subtract unit: one quotient bit per cycle.
module idiv_core #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  idiv_pkg::core_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0]  op_a,
    input  logic [DATA_WIDTH-1:0]  op_b,
    output idiv_pkg::core_stat_t   stat,
    output logic [DATA_WIDTH-1:0]  quo,
    output logic [DATA_WIDTH-1:0]  rem
);

    localparam int CNT_WIDTH = $clog2(DATA_WIDTH + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   trial;
    logic                  last;

    // One trial subtraction of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign last    = busy_reg && (cnt_reg == CNT_WIDTH'(1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_WIDTH'(DATA_WIDTH);
            rem_next  = '0;
            quo_next  = op_a;
            dvs_next  = op_b;
        end
        else if (busy_reg)
        begin
            // no borrow: keep the difference and shift in a one
            if (!trial[DATA_WIDTH])
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = last;
    assign quo = quo_next;
    assign rem = rem_next;

endmodule

FILE: rtl/core/integer_divider_signed_unsigned.sv
// After an item is accepted, the sequencer steps through ST_RUN and ST_FIX before the
// registered result is posted. The restoring loop retires one quotient bit per cycle
// in the shared shift-subtract unit; ST_FIX does the sign fix-up and waits for a free
// output slot, and the next item is taken only once the sequencer is back in idle.
// in_ready is high only while the sequencer is idle; a held result does not block it.
// Reset (rst_n, async, active low) returns the sequencer to idle with no result pending.
module integer_divider_signed_unsigned #(
    parameter int DATA_WIDTH = idiv_pkg::DEF_DATA_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [idiv_pkg::MODE_WIDTH-1:0]   mode,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  dividend,
    input  logic [idiv_pkg::FIELD_WIDTH-1:0]  divisor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [idiv_pkg::FIELD_WIDTH-1:0]  result,
    output logic                              divide_by_zero
);

    localparam int MAXW = idiv_pkg::MAX_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                  out_valid_reg, out_valid_next;
    logic [idiv_pkg::FIELD_WIDTH-1:0] result_reg, result_next;
    logic                  dz_out_reg, dz_out_next;

    logic                  want_rem_reg;
    logic                  neg_reg;
    logic                  dz_reg;
    logic [DATA_WIDTH-1:0] a_raw_reg;
    logic [DATA_WIDTH-1:0] quo_hold_reg;
    logic [DATA_WIDTH-1:0] rem_hold_reg;

    logic                  accept;
    logic [MAXW-1:0]       a_ext, b_ext;
    logic [DATA_WIDTH-1:0] a_w, b_w;
    logic                  a_neg, b_neg, is_signed, want_rem;
    logic [DATA_WIDTH-1:0] a_mag, b_mag;
    logic [DATA_WIDTH-1:0] core_quo, core_rem;
    logic [DATA_WIDTH-1:0] pick, fixed;
    logic [MAXW-1:0]       fixed_ext;
    logic                  out_free;

    idiv_pkg::core_ctrl_t  core_ctrl;
    idiv_pkg::core_stat_t  core_stat;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    // Operand decode: take the low DATA_WIDTH bits and form magnitudes
    assign a_ext     = MAXW'(dividend);
    assign b_ext     = MAXW'(divisor);
    assign a_w       = a_ext[DATA_WIDTH-1:0];
    assign b_w       = b_ext[DATA_WIDTH-1:0];
    assign is_signed = mode[idiv_pkg::MODE_SIGNED_BIT];
    assign want_rem  = mode[idiv_pkg::MODE_REM_BIT];
    assign a_neg     = is_signed && a_w[DATA_WIDTH-1];
    assign b_neg     = is_signed && b_w[DATA_WIDTH-1];
    assign a_mag     = a_neg ? (DATA_WIDTH'(0) - a_w) : a_w;
    assign b_mag     = b_neg ? (DATA_WIDTH'(0) - b_w) : b_w;

    assign core_ctrl.start = accept;

    idiv_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .op_a  (a_mag),
        .op_b  (b_mag),
        .stat  (core_stat),
        .quo   (core_quo),
        .rem   (core_rem)
    );

    // Item attributes captured at accept, final quotient/remainder at the last step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            want_rem_reg <= want_rem;
            neg_reg      <= want_rem ? a_neg : (a_neg != b_neg);
            dz_reg       <= (b_w == '0);
            a_raw_reg    <= a_w;
        end
        if (core_stat.done)
        begin
            quo_hold_reg <= core_quo;
            rem_hold_reg <= core_rem;
        end
    end

    // Sign fix-up and divide-by-zero override
    always_comb
    begin
        pick = want_rem_reg ? rem_hold_reg : quo_hold_reg;
        if (dz_reg)
        begin
            fixed = want_rem_reg ? a_raw_reg : '1;
        end
        else if (neg_reg)
        begin
            fixed = DATA_WIDTH'(0) - pick;
        end
        else
        begin
            fixed = pick;
        end
        fixed_ext = MAXW'(fixed);
    end

    // Sequencer and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        dz_out_next    = dz_out_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (core_stat.done)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = fixed_ext[idiv_pkg::FIELD_WIDTH-1:0];
                    dz_out_next    = dz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        dz_out_reg <= dz_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign divide_by_zero = dz_out_reg;

    // The unit is never busy while a new item can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !core_stat.busy)
        else $error("divider busy while sequencer idle");

    // Completion of the shift-subtract loop only while running
    assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> (state_reg == ST_RUN))
        else $error("loop done outside run state");

    // An accepted item starts the loop
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (core_stat.busy && state_reg == ST_RUN))
        else $error("accepted item did not start the loop");

    // Fix-up with a free output slot always posts a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIX && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("result not posted after fix-up");

endmodule
